// ----- hdl/dts_pkg.sv -----
// ----------------------------------------------------------------------------
// dts_pkg: shared types and constants of the depth-first topological sorter
// Command and result words, opcodes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package dts_pkg;

    localparam int NODE_W        = 6;
    localparam int OP_W          = 2;
    localparam int ST_W          = 2;
    localparam int DEF_MAX_NODES = 64;
    localparam int DEF_MAX_EDGES = 256;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_NODE = 2'd0,
        OP_ADD_EDGE = 2'd1,
        OP_SORT     = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } t_cmd;

    typedef struct packed {
        logic [NODE_W-1:0] node_out;
        logic [ST_W-1:0]   status;
        logic              last;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE,
        S_SCAN,
        S_HEAD,
        S_STEP,
        S_EDGE_RD,
        S_POP,
        S_EMIT
    } t_state;

endpackage

// ----- hdl/dfs_topological_sort.sv -----
// ----------------------------------------------------------------------------
// dfs_topological_sort: graph builder and depth-first topological sorter
// Adds nodes and edges to adjacency lists held in RAM, and on command walks
// the graph depth first and emits the nodes in reverse finishing order.
// ----------------------------------------------------------------------------
//  channel   | ports                      | handshake
//  ----------+----------------------------+-------------------------------
//  command   | start, busy, i_cmd         | taken when start & !busy
//  result    | o_strobe, o_result         | each word for one cycle, no stall
//
// Add node: result word the cycle after it is taken. Add edge: a further S_EDGE
// step does the list head/tail read-modify-write through the registered RAM read.
// Sort: scans node ids; an entered node passes S_HEAD and S_STEP, a followed
// edge S_STEP and S_EDGE_RD, a finished non-root node S_STEP and S_POP (RAM
// reads registered), then one result word per cycle from the finish-order RAM.
// Reset clears presence, list and visit marks at once; no clearing pass.
// The receiver cannot stall; every result word is shown for one cycle.
// ----------------------------------------------------------------------------
module dfs_topological_sort #(
    parameter int MAX_NODES = dts_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = dts_pkg::DEF_MAX_EDGES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  dts_pkg::t_cmd    i_cmd,
    output logic             o_strobe,
    output dts_pkg::t_result o_result
);
    import dts_pkg::*;

    localparam int NW = $clog2(MAX_NODES);      // node index
    localparam int DW = $clog2(MAX_NODES + 1);  // depth / count
    localparam int AW = $clog2(MAX_EDGES);      // edge index
    localparam int EW = $clog2(MAX_EDGES + 1);  // edge index plus null
    localparam logic [EW-1:0] NULL_EDGE = EW'(MAX_EDGES);

    // control state
    t_state             r_state, n_state;
    logic [MAX_NODES-1:0] r_present, n_present;
    logic [MAX_NODES-1:0] r_has_edges, n_has_edges;
    logic [MAX_NODES-1:0] r_visited, n_visited;
    logic [EW-1:0]      r_used, n_used;
    logic [NW-1:0]      r_scan, n_scan;
    logic [DW-1:0]      r_depth, n_depth;
    logic [DW-1:0]      r_done, n_done;
    logic [DW-1:0]      r_cnt, n_cnt;
    logic               r_strobe, n_strobe;
    logic               r_pend, n_pend;

    // payload
    logic [NW-1:0]      r_a, n_a;
    logic [AW-1:0]      r_e, n_e;
    logic [NW-1:0]      r_node, n_node;
    logic [EW-1:0]      r_cur, n_cur;
    t_result            r_result, n_result;
    logic               r_pend_last, n_pend_last;

    // RAM ports
    logic               list_we;
    logic [NW-1:0]      list_waddr, list_raddr;
    logic [2*AW-1:0]    list_wdata, list_rdata;
    logic               tgt_we;
    logic [AW-1:0]      tgt_waddr;
    logic [NODE_W-1:0]  tgt_wdata, tgt_rdata;
    logic               link_we;
    logic [AW-1:0]      link_waddr;
    logic [EW-1:0]      link_wdata, link_rdata;
    logic               stk_we;
    logic [NW-1:0]      stk_waddr, stk_raddr;
    logic [NW+EW-1:0]   stk_wdata, stk_rdata;
    logic               fin_we;
    logic [NW-1:0]      fin_waddr, fin_raddr;
    logic [NW-1:0]      fin_wdata, fin_rdata;

    // decoded command
    logic               w_accept;
    logic               a_ok, b_ok, nb_ok;
    logic [NW-1:0]      a_idx, b_idx, nb_idx;
    logic               edge_err, edge_full;
    logic [AW-1:0]      list_head, list_tail;
    logic               push_ok;
    logic [DW-1:0]      depth_m1, depth_m2, cnt_m1;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    assign a_ok   = {1'b0, i_cmd.node_a} < (NODE_W + 1)'(MAX_NODES);
    assign b_ok   = {1'b0, i_cmd.node_b} < (NODE_W + 1)'(MAX_NODES);
    assign a_idx  = i_cmd.node_a[NW-1:0];
    assign b_idx  = i_cmd.node_b[NW-1:0];
    assign nb_ok  = {1'b0, tgt_rdata} < (NODE_W + 1)'(MAX_NODES);
    assign nb_idx = tgt_rdata[NW-1:0];

    assign edge_err  = !a_ok || !b_ok || !r_present[a_idx];
    assign edge_full = (r_used >= EW'(MAX_EDGES));

    assign list_head = list_rdata[2*AW-1:AW];
    assign list_tail = list_rdata[AW-1:0];

    assign depth_m1 = r_depth - DW'(1);
    assign depth_m2 = r_depth - DW'(2);
    assign cnt_m1   = r_cnt - DW'(1);
    assign push_ok  = nb_ok && !r_visited[nb_idx] && (r_depth < DW'(MAX_NODES));

    // read addresses: chosen by state
    always_comb begin
        unique case (r_state)
            S_IDLE:    list_raddr = a_idx;
            S_SCAN:    list_raddr = r_scan;
            default:   list_raddr = nb_idx;
        endcase
    end
    assign stk_raddr = depth_m2[NW-1:0];
    assign fin_raddr = cnt_m1[NW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_cmd.opcode == OP_ADD_EDGE && !edge_err && !edge_full) begin
                        n_state = S_EDGE;
                    end else if (i_cmd.opcode == OP_SORT && (r_present != '0)) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_EDGE: n_state = S_IDLE;
            S_SCAN: begin
                if (r_present[r_scan] && !r_visited[r_scan]) begin
                    n_state = S_HEAD;
                end else if (r_scan == NW'(MAX_NODES - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_HEAD: n_state = S_STEP;
            S_STEP: begin
                if (r_cur < NULL_EDGE) begin
                    n_state = S_EDGE_RD;
                end else if (r_depth == DW'(1)) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_POP;
                end
            end
            S_EDGE_RD: n_state = push_ok ? S_HEAD : S_STEP;
            S_POP:     n_state = S_STEP;
            S_EMIT:    n_state = (r_cnt == '0) ? S_IDLE : S_EMIT;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and RAM writes
    always_comb begin
        n_present   = r_present;
        n_has_edges = r_has_edges;
        n_visited   = r_visited;
        n_used      = r_used;
        n_scan      = r_scan;
        n_depth     = r_depth;
        n_done      = r_done;
        n_cnt       = r_cnt;
        n_strobe    = 1'b0;
        n_pend      = 1'b0;
        n_a         = r_a;
        n_e         = r_e;
        n_node      = r_node;
        n_cur       = r_cur;
        n_result    = r_result;
        n_pend_last = r_pend_last;
        list_we     = 1'b0;
        list_waddr  = r_a;
        list_wdata  = {r_e, r_e};
        tgt_we      = 1'b0;
        tgt_waddr   = r_used[AW-1:0];
        tgt_wdata   = i_cmd.node_b;
        link_we     = 1'b0;
        link_waddr  = r_used[AW-1:0];
        link_wdata  = NULL_EDGE;
        stk_we      = 1'b0;
        stk_waddr   = depth_m1[NW-1:0];
        stk_wdata   = {r_node, link_rdata};
        fin_we      = 1'b0;
        fin_waddr   = r_done[NW-1:0];
        fin_wdata   = r_node;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_cmd.opcode)
                        OP_ADD_NODE: begin
                            if (a_ok) begin
                                n_present[a_idx]   = 1'b1;
                                n_has_edges[a_idx] = 1'b0;
                            end
                            n_strobe = 1'b1;
                            n_result = '{node_out: '0, status: ST_OK, last: 1'b1};
                        end
                        OP_ADD_EDGE: begin
                            if (edge_err) begin
                                n_strobe = 1'b1;
                                n_result = '{node_out: '0, status: ST_MISSING, last: 1'b1};
                            end else if (edge_full) begin
                                n_strobe = 1'b1;
                                n_result = '{node_out: '0, status: ST_FULL, last: 1'b1};
                            end else begin
                                // allocate; the list itself is patched next cycle
                                tgt_we           = 1'b1;
                                link_we          = 1'b1;
                                n_present[b_idx] = 1'b1;
                                n_a              = a_idx;
                                n_e              = r_used[AW-1:0];
                                n_used           = r_used + EW'(1);
                            end
                        end
                        OP_SORT: begin
                            if (r_present == '0) begin
                                n_strobe = 1'b1;
                                n_result = '{node_out: '0, status: ST_EMPTY, last: 1'b1};
                            end else begin
                                n_visited = '0;
                                n_scan    = '0;
                                n_done    = '0;
                                n_depth   = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_EDGE: begin
                // append to the tail, or start a new list
                list_we = 1'b1;
                if (r_has_edges[r_a]) begin
                    link_we    = 1'b1;
                    link_waddr = list_tail;
                    link_wdata = EW'(r_e);
                    list_wdata = {list_head, r_e};
                end
                n_has_edges[r_a] = 1'b1;
                n_strobe = 1'b1;
                n_result = '{node_out: '0, status: ST_OK, last: 1'b1};
            end
            S_SCAN: begin
                if (r_present[r_scan] && !r_visited[r_scan]) begin
                    n_visited[r_scan] = 1'b1;
                    n_node            = r_scan;
                    n_depth           = DW'(1);
                end else if (r_scan == NW'(MAX_NODES - 1)) begin
                    n_cnt = r_done;
                end else begin
                    n_scan = r_scan + NW'(1);
                end
            end
            S_HEAD: begin
                n_cur = r_has_edges[r_node] ? EW'(list_head) : NULL_EDGE;
            end
            S_STEP: begin
                if (r_cur >= NULL_EDGE) begin
                    // node finished: record, then pop
                    fin_we = 1'b1;
                    n_done = r_done + DW'(1);
                    if (r_depth == DW'(1)) begin
                        n_depth = '0;
                    end
                end
            end
            S_EDGE_RD: begin
                n_cur = link_rdata;
                if (push_ok) begin
                    n_visited[nb_idx] = 1'b1;
                    stk_we            = 1'b1;
                    n_node            = nb_idx;
                    n_depth           = r_depth + DW'(1);
                end
            end
            S_POP: begin
                n_node  = stk_rdata[NW+EW-1:EW];
                n_cur   = stk_rdata[EW-1:0];
                n_depth = depth_m1;
            end
            S_EMIT: begin
                if (r_cnt != '0) begin
                    n_pend      = 1'b1;
                    n_pend_last = (r_cnt == DW'(1));
                    n_cnt       = cnt_m1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_present   <= '0;
            r_has_edges <= '0;
            r_visited   <= '0;
            r_used      <= '0;
            r_scan      <= '0;
            r_depth     <= '0;
            r_done      <= '0;
            r_cnt       <= '0;
            r_strobe    <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_present   <= n_present;
            r_has_edges <= n_has_edges;
            r_visited   <= n_visited;
            r_used      <= n_used;
            r_scan      <= n_scan;
            r_depth     <= n_depth;
            r_done      <= n_done;
            r_cnt       <= n_cnt;
            r_strobe    <= n_strobe;
            r_pend      <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a         <= n_a;
        r_e         <= n_e;
        r_node      <= n_node;
        r_cur       <= n_cur;
        r_result    <= n_result;
        r_pend_last <= n_pend_last;
    end

    // order words come straight from the finish RAM read register
    assign o_strobe = r_strobe || r_pend;
    assign o_result = r_pend
        ? t_result'{node_out: NODE_W'(fin_rdata), status: ST_OK, last: r_pend_last}
        : r_result;

    // head/tail per node
    dts_ram #(.WIDTH(2 * AW), .DEPTH(MAX_NODES)) u_list (
        .i_clk(i_clk), .i_we(list_we), .i_waddr(list_waddr), .i_wdata(list_wdata),
        .i_raddr(list_raddr), .o_rdata(list_rdata)
    );

    // edge destinations
    dts_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_target (
        .i_clk(i_clk), .i_we(tgt_we), .i_waddr(tgt_waddr), .i_wdata(tgt_wdata),
        .i_raddr(r_cur[AW-1:0]), .o_rdata(tgt_rdata)
    );

    // next edge in list
    dts_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_link (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_waddr), .i_wdata(link_wdata),
        .i_raddr(r_cur[AW-1:0]), .o_rdata(link_rdata)
    );

    // walk stack below the top entry
    dts_ram #(.WIDTH(NW + EW), .DEPTH(MAX_NODES)) u_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    // finishing order
    dts_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_finish (
        .i_clk(i_clk), .i_we(fin_we), .i_waddr(fin_waddr), .i_wdata(fin_wdata),
        .i_raddr(fin_raddr), .o_rdata(fin_rdata)
    );

    // status word and order word never collide
    a_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_strobe && r_pend))
        else $error("status and order words overlap");

    // walk stack stays in bounds
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(MAX_NODES))
        else $error("walk depth overflow");

    // a step always has a node on the stack
    a_step_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> (r_depth != '0))
        else $error("step with empty stack");

    // an order word only follows an emit read
    a_pend_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(r_state == S_EMIT))
        else $error("order word without emit");

endmodule

// ----- hdl/dts_ram.sv -----
// ----------------------------------------------------------------------------
// dts_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
